// ===== rtl/edfrm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfrm_pkg
// Shared types and constants of the EDF and RM tick scheduler.
// ----------------------------------------------------------------------------
package edfrm_pkg;

    localparam int NUM_TASK_WORDS = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int DIVIDEND_W     = 32;
    localparam int DIVISOR_W      = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK3      = 3'd5;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_START   = 2'd1;
    localparam logic [1:0] EV_PREEMPT = 2'd2;

    typedef struct packed {
        logic [1:0]  task_id;
        logic [31:0] deadline;
        logic [15:0] remaining;
    } job_t;

    typedef struct packed {
        logic                 done;
        logic [DIVISOR_W-1:0] remainder;
    } rem_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REL_CHK,
        S_REL_DIV,
        S_SCAN_INIT,
        S_SCAN_RD,
        S_SCAN_EV,
        S_DECIDE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_EXEC
    } state_t;

endpackage

// ===== rtl/edfrm_rem_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edfrm_rem_unit
// Restoring remainder unit: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module edfrm_rem_unit
    import edfrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output rem_stat_t             stat
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    logic [DIVISOR_W:0]    trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        if (start)
        begin
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            cnt_next = CNT_W'(DIVIDEND_W);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = DIVISOR_W'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[DIVISOR_W-1:0];
            end
            dvd_next  = {dvd_reg[DIVIDEND_W-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
    end

    assign stat.done      = done_reg;
    assign stat.remainder = rem_reg;

endmodule

// ===== rtl/edf_rm_tick_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_rm_tick_scheduler
// Periodic task scheduler, one tick per transaction, EDF or RM selection.
// After acceptance each task descriptor is skipped or sent through the serial
// remainder unit, each queued entry is scanned, the choice is decided, and on a
// start from idle the vacated slot is refilled from the last queued entry.
// One tick is taken at a time; a tick of zero is absorbed while idle. A pending
// report stalls only the final state, S_EXEC.
// Reset clears counters, time, tallies and configuration; the queue needs none.
// ----------------------------------------------------------------------------
module edf_rm_tick_scheduler
    import edfrm_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int TASK_SLOTS  = 4
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 tick,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [31:0]          tick_time,
    output logic                 busy_res,
    output logic [1:0]           running_task,
    output logic [1:0]           dispatch_event,
    output logic                 finished,
    output logic [4:0]           misses_in_tick,
    output logic [31:0]          running_deadline,
    output logic [15:0]          running_remaining,
    output logic [31:0]          completed_total,
    output logic [31:0]          preemptions_total,
    output logic [31:0]          misses_total,
    output logic                 dropped,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int QW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int MW = $clog2(QUEUE_DEPTH + 2);

    state_t           state_reg, state_next;
    logic [2:0]       ti_reg, ti_next;
    logic [QW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [31:0]      now_reg, now_next;
    logic             held_reg, held_next;
    job_t             cur_reg, cur_next;
    logic [31:0]      tal_c_reg, tal_c_next;
    logic [31:0]      tal_p_reg, tal_p_next;
    logic [31:0]      tal_m_reg, tal_m_next;
    logic [MW-1:0]    miss_reg, miss_next;
    logic             drop_reg, drop_next;
    logic [1:0]       event_reg, event_next;
    job_t             best_reg, best_next;
    logic [QW-1:0]    bidx_reg, bidx_next;
    logic             oval_reg, oval_next;
    logic [31:0]      o_time_reg, o_time_next;
    logic             o_busy_reg, o_busy_next;
    logic [1:0]       o_task_reg, o_task_next;
    logic [1:0]       o_ev_reg, o_ev_next;
    logic             o_fin_reg, o_fin_next;
    logic [4:0]       o_miss_reg, o_miss_next;
    logic [31:0]      o_dl_reg, o_dl_next;
    logic [15:0]      o_rem_reg, o_rem_next;
    logic             o_drop_reg, o_drop_next;
    logic [31:0]      o_tc_reg, o_tc_next;
    logic [31:0]      o_tp_reg, o_tp_next;
    logic [31:0]      o_tm_reg, o_tm_next;

    logic             policy_reg;
    logic [2:0]       tcount_reg;
    logic [63:0]      tw_reg [NUM_TASK_WORDS];

    job_t             mem [QUEUE_DEPTH];
    job_t             rdata_reg;
    logic [QW-1:0]    raddr;
    logic             we;
    logic [QW-1:0]    waddr;
    job_t             wdata;

    logic             div_start;
    logic [31:0]      div_dividend;
    logic [15:0]      div_divisor;
    rem_stat_t        div_stat;

    logic [2:0]       n_tasks;
    logic [63:0]      tw_cur;
    logic [15:0]      per_cur;
    logic [15:0]      phase_cur;
    logic             better;
    logic             pre;
    logic [15:0]      new_rem;
    logic [31:0]      miss_ext;
    logic [32:0]      msum;

    function automatic logic [31:0] sat_inc(input logic [31:0] a);
        return (a == 32'hFFFF_FFFF) ? a : a + 32'd1;
    endfunction

    edfrm_rem_unit u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat)
    );

    assign n_tasks   = (tcount_reg > 3'(TASK_SLOTS)) ? 3'(TASK_SLOTS) : tcount_reg;
    assign tw_cur    = tw_reg[ti_reg[1:0]];
    assign per_cur   = tw_cur[15:0];
    assign phase_cur = tw_cur[63:48];
    assign div_dividend = now_reg - {16'd0, phase_cur};
    assign div_divisor  = per_cur;
    assign new_rem   = (cur_reg.remaining != 16'd0) ? cur_reg.remaining - 16'd1 : 16'd0;
    assign miss_ext  = 32'(miss_reg);
    assign msum      = {1'b0, tal_m_reg} + {1'b0, miss_ext};

    always_comb
    begin
        logic [15:0] pa;
        logic [15:0] pb;
        pa = tw_reg[rdata_reg.task_id][15:0];
        pb = tw_reg[best_reg.task_id][15:0];
        if (policy_reg == 1'b0)
        begin
            better = rdata_reg.deadline < best_reg.deadline;
        end
        else if (pa != pb)
        begin
            better = pa < pb;
        end
        else if (rdata_reg.deadline != best_reg.deadline)
        begin
            better = rdata_reg.deadline < best_reg.deadline;
        end
        else
        begin
            better = rdata_reg.task_id < best_reg.task_id;
        end
    end

    always_comb
    begin
        logic [15:0] pc;
        logic [15:0] pr;
        pc = tw_reg[best_reg.task_id][15:0];
        pr = tw_reg[cur_reg.task_id][15:0];
        if (policy_reg == 1'b0)
        begin
            pre = best_reg.deadline < cur_reg.deadline;
        end
        else
        begin
            pre = (pc < pr) || ((pc == pr) && (best_reg.task_id < cur_reg.task_id));
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        ti_next     = ti_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        now_next    = now_reg;
        held_next   = held_reg;
        cur_next    = cur_reg;
        tal_c_next  = tal_c_reg;
        tal_p_next  = tal_p_reg;
        tal_m_next  = tal_m_reg;
        miss_next   = miss_reg;
        drop_next   = drop_reg;
        event_next  = event_reg;
        best_next   = best_reg;
        bidx_next   = bidx_reg;
        oval_next   = oval_reg & ~out_ready;
        o_time_next = o_time_reg;
        o_busy_next = o_busy_reg;
        o_task_next = o_task_reg;
        o_ev_next   = o_ev_reg;
        o_fin_next  = o_fin_reg;
        o_miss_next = o_miss_reg;
        o_dl_next   = o_dl_reg;
        o_rem_next  = o_rem_reg;
        o_drop_next = o_drop_reg;
        o_tc_next   = o_tc_reg;
        o_tp_next   = o_tp_reg;
        o_tm_next   = o_tm_reg;
        raddr       = idx_reg;
        we          = 1'b0;
        waddr       = count_reg[QW-1:0];
        wdata       = best_reg;
        div_start   = 1'b0;
        in_ready    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && tick)
                begin
                    ti_next    = 3'd0;
                    drop_next  = 1'b0;
                    event_next = EV_NONE;
                    state_next = S_REL_CHK;
                end
            end
            S_REL_CHK:
            begin
                if (ti_reg >= n_tasks)
                begin
                    state_next = S_SCAN_INIT;
                end
                else if ((per_cur == 16'd0) || (now_reg < {16'd0, phase_cur}))
                begin
                    ti_next = ti_reg + 3'd1;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_REL_DIV;
                end
            end
            S_REL_DIV:
            begin
                if (div_stat.done)
                begin
                    if (div_stat.remainder == 16'd0)
                    begin
                        if (count_reg < CW'(QUEUE_DEPTH))
                        begin
                            we               = 1'b1;
                            waddr            = count_reg[QW-1:0];
                            wdata.task_id    = ti_reg[1:0];
                            wdata.deadline   = now_reg + {16'd0, tw_cur[47:32]};
                            wdata.remaining  = tw_cur[31:16];
                            count_next       = count_reg + CW'(1);
                        end
                        else
                        begin
                            drop_next = 1'b1;
                        end
                    end
                    ti_next    = ti_reg + 3'd1;
                    state_next = S_REL_CHK;
                end
            end
            S_SCAN_INIT:
            begin
                miss_next = (held_reg && (now_reg > cur_reg.deadline)
                             && (cur_reg.remaining != 16'd0)) ? MW'(1) : MW'(0);
                idx_next  = '0;
                state_next = (count_reg == '0) ? S_EXEC : S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                raddr      = idx_reg;
                state_next = S_SCAN_EV;
            end
            S_SCAN_EV:
            begin
                if ((now_reg > rdata_reg.deadline) && (rdata_reg.remaining != 16'd0))
                begin
                    miss_next = miss_reg + MW'(1);
                end
                if ((idx_reg == '0) || better)
                begin
                    best_next = rdata_reg;
                    bidx_next = idx_reg;
                end
                idx_next = idx_reg + QW'(1);
                state_next = ((CW'(idx_reg) + CW'(1)) == count_reg) ? S_DECIDE : S_SCAN_RD;
            end
            S_DECIDE:
            begin
                if (!held_reg)
                begin
                    cur_next   = best_reg;
                    count_next = count_reg - CW'(1);
                    held_next  = 1'b1;
                    event_next = EV_START;
                    state_next = S_MOVE_RD;
                end
                else if (pre)
                begin
                    we         = 1'b1;
                    waddr      = bidx_reg;
                    wdata      = cur_reg;
                    cur_next   = best_reg;
                    tal_p_next = sat_inc(tal_p_reg);
                    event_next = EV_PREEMPT;
                    state_next = S_EXEC;
                end
                else
                begin
                    state_next = S_EXEC;
                end
            end
            S_MOVE_RD:
            begin
                raddr      = count_reg[QW-1:0];
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                we         = 1'b1;
                waddr      = bidx_reg;
                wdata      = rdata_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (!oval_reg || out_ready)
                begin
                    oval_next   = 1'b1;
                    o_time_next = now_reg;
                    o_busy_next = held_reg;
                    o_task_next = held_reg ? cur_reg.task_id : 2'd0;
                    o_ev_next   = event_reg;
                    o_fin_next  = held_reg && (new_rem == 16'd0);
                    o_miss_next = (miss_ext > 32'd31) ? 5'd31 : miss_ext[4:0];
                    o_dl_next   = held_reg ? cur_reg.deadline : 32'd0;
                    o_rem_next  = held_reg ? new_rem : 16'd0;
                    o_drop_next = drop_reg;
                    tal_m_next  = msum[32] ? 32'hFFFF_FFFF : msum[31:0];
                    if (held_reg)
                    begin
                        cur_next.remaining = new_rem;
                        if (new_rem == 16'd0)
                        begin
                            held_next  = 1'b0;
                            tal_c_next = sat_inc(tal_c_reg);
                        end
                    end
                    o_tc_next  = tal_c_next;
                    o_tp_next  = tal_p_reg;
                    o_tm_next  = tal_m_next;
                    now_next   = now_reg + 32'd1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ti_reg     <= '0;
            idx_reg    <= '0;
            count_reg  <= '0;
            now_reg    <= '0;
            held_reg   <= 1'b0;
            cur_reg    <= '0;
            tal_c_reg  <= '0;
            tal_p_reg  <= '0;
            tal_m_reg  <= '0;
            miss_reg   <= '0;
            drop_reg   <= 1'b0;
            event_reg  <= EV_NONE;
            oval_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ti_reg     <= ti_next;
            idx_reg    <= idx_next;
            count_reg  <= count_next;
            now_reg    <= now_next;
            held_reg   <= held_next;
            cur_reg    <= cur_next;
            tal_c_reg  <= tal_c_next;
            tal_p_reg  <= tal_p_next;
            tal_m_reg  <= tal_m_next;
            miss_reg   <= miss_next;
            drop_reg   <= drop_next;
            event_reg  <= event_next;
            oval_reg   <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg   <= best_next;
        bidx_reg   <= bidx_next;
        o_time_reg <= o_time_next;
        o_busy_reg <= o_busy_next;
        o_task_reg <= o_task_next;
        o_ev_reg   <= o_ev_next;
        o_fin_reg  <= o_fin_next;
        o_miss_reg <= o_miss_next;
        o_dl_reg   <= o_dl_next;
        o_rem_reg  <= o_rem_next;
        o_drop_reg <= o_drop_next;
        o_tc_reg   <= o_tc_next;
        o_tp_reg   <= o_tp_next;
        o_tm_reg   <= o_tm_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= 1'b0;
            tcount_reg <= '0;
            for (int k = 0; k < NUM_TASK_WORDS; k++)
            begin
                tw_reg[k] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_POLICY)
            begin
                policy_reg <= cfg_data[0];
            end
            else if (cfg_index == CFG_TASK_COUNT)
            begin
                tcount_reg <= cfg_data[2:0];
            end
            else if ((cfg_index >= CFG_TASK0) && (cfg_index <= CFG_TASK3))
            begin
                tw_reg[2'(cfg_index - CFG_TASK0)] <= cfg_data;
            end
        end
    end

    assign cfg_ready         = 1'b1;
    assign out_valid         = oval_reg;
    assign tick_time         = o_time_reg;
    assign busy_res          = o_busy_reg;
    assign running_task      = o_task_reg;
    assign dispatch_event    = o_ev_reg;
    assign finished          = o_fin_reg;
    assign misses_in_tick    = o_miss_reg;
    assign running_deadline  = o_dl_reg;
    assign running_remaining = o_rem_reg;
    assign completed_total   = o_tc_reg;
    assign preemptions_total = o_tp_reg;
    assign misses_total      = o_tm_reg;
    assign dropped           = o_drop_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(QUEUE_DEPTH))
        else $error("Ready queue count exceeds its depth.");

    a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |-> (running_deadline == 32'd0 && running_remaining == 16'd0
                                      && !finished && dispatch_event == EV_NONE))
        else $error("Idle tick reports a running job.");

    a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dispatch_event != 2'd3))
        else $error("Dispatch event code out of range.");

    a_start_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && !held_reg) |=> held_reg)
        else $error("Dispatch from idle did not take the processor.");

endmodule
